// ===== rtl/ssp_pkg.sv =====
// Shared types and constants for the superpixel segment pooling block.
// No dependencies; every other file of the block imports this package.
package ssp_pkg;

  // Default number of segment cells in the chain.
  localparam int unsigned SSP_MAX_SEG = 64;

  // Field widths fixed by the interface.
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned LBL_W   = 8;
  localparam int unsigned IDX_OUT_W = 6;
  localparam int unsigned NSEG_W  = 7;
  localparam int unsigned ACC_W   = 33;
  localparam int unsigned CNT_W   = 17;

  // Configuration port.
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;

  // Register indexes.
  localparam logic REG_POOL_MODE = 1'b0;
  localparam logic REG_NUM_SEG   = 1'b1;

  // Pooling modes.
  localparam logic MODE_MAX = 1'b0;
  localparam logic MODE_AVG = 1'b1;

  // Q8.8 limits.
  localparam logic signed [VAL_W-1:0] VAL_MIN = 16'sh8000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 16'sh7FFF;

  // One pixel request.
  typedef struct packed {
    logic signed [VAL_W-1:0] pixel_value;
    logic [LBL_W-1:0]        superpixel_label;
    logic                    end_of_channel;
  } ssp_in_t;

  // One pooled result.
  typedef struct packed {
    logic [IDX_OUT_W-1:0]    label_index;
    logic signed [VAL_W-1:0] pooled_value;
    logic                    empty_segment;
    logic                    last_result;
  } ssp_out_t;

  // State held by one segment cell.
  typedef struct packed {
    logic signed [ACC_W-1:0] acc;
    logic [CNT_W-1:0]        cnt;
  } ssp_seg_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic upd;
    logic shift;
    logic clr;
    logic avg;
  } ssp_cell_ctl_t;

endpackage

// ===== rtl/superpixel_segment_pooling.sv =====
// Superpixel segment pooling top level: a chain of segment cells, a serial
// divider and the emission control. Uses ssp_pkg, ssp_cell and ssp_div.
//
// Pixels are taken one per cycle while the block accumulates; each pixel
// with a label below the active count updates its label's cell in the same
// cycle. The pixel that marks the end of the channel starts emission: the
// cell chain shifts toward cell 0 one entry per result, and in max mode each
// result passes the load and output states, staying in output while the
// consumer stalls. In average mode a non-empty segment also passes the
// bit-serial divider. No pixel is taken during emission; after the final
// result is taken all cells clear and pixels are taken in the next cycle.
module superpixel_segment_pooling import ssp_pkg::*; #(
  parameter int unsigned MAX_SUPERPIXELS = SSP_MAX_SEG
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // pixel requests
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ssp_in_t           in_req_i,
  // pooled results
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ssp_out_t          out_res_o,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned IDX_W = (MAX_SUPERPIXELS > 1) ? $clog2(MAX_SUPERPIXELS) : 1;

  typedef enum logic [1:0] {
    S_ACCUM,
    S_LOAD,
    S_DIV,
    S_OUT
  } state_e;

  state_e            state_q;
  logic              mode_q;
  logic [NSEG_W-1:0] nseg_q;
  logic [IDX_W-1:0]  idx_q;
  logic              last_q;
  logic              neg_q;
  logic              out_valid_q;
  ssp_out_t          out_q;

  ssp_seg_t          seg[MAX_SUPERPIXELS];
  ssp_cell_ctl_t     ctl;
  logic [NSEG_W-1:0] active;
  logic              in_acc;
  logic              out_acc;
  logic              cfg_wr;
  logic              wr_mode;
  logic              div_start;
  logic              div_done;
  logic [ACC_W-1:0]  div_quot;
  logic [ACC_W-1:0]  mag;
  logic              load_last;
  logic signed [VAL_W-1:0] avg_res;

  // Configuration write decode.
  assign cfg_wr  = psel && penable && pwrite;
  assign wr_mode = cfg_wr && (paddr[2] == REG_POOL_MODE);
  assign pready  = 1'b1;

  always_comb begin
    unique case (paddr[2])
      REG_POOL_MODE: prdata = APB_DW'(mode_q);
      REG_NUM_SEG:   prdata = APB_DW'(nseg_q);
      default:       prdata = '0;
    endcase
  end

  // Active label count, clamped to one and to the chain length.
  always_comb begin
    if (nseg_q == '0) begin
      active = NSEG_W'(1);
    end else if (nseg_q > NSEG_W'(MAX_SUPERPIXELS)) begin
      active = NSEG_W'(MAX_SUPERPIXELS);
    end else begin
      active = nseg_q;
    end
  end

  assign in_stall_o = (state_q != S_ACCUM);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;

  // Cell control.
  always_comb begin
    ctl.upd   = in_acc && ({1'b0, in_req_i.superpixel_label} < {2'b00, active});
    ctl.shift = (state_q == S_LOAD);
    ctl.clr   = wr_mode || ((state_q == S_OUT) && out_acc && last_q);
    ctl.avg   = mode_q;
  end

  // The chain of segment cells; the tail shifts in an empty entry.
  for (genvar k = 0; k < MAX_SUPERPIXELS; k++) begin : g_cell
    ssp_seg_t nxt;
    if (k == MAX_SUPERPIXELS - 1) begin : g_tail
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = seg[k+1];
    end
    ssp_cell #(
      .CELL_ID (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .value_i (in_req_i.pixel_value),
      .label_i (in_req_i.superpixel_label),
      .next_i  (nxt),
      .seg_o   (seg[k])
    );
  end

  // Head cell magnitude for the divider.
  assign mag       = seg[0].acc[ACC_W-1] ? (~seg[0].acc + 1'b1) : seg[0].acc;
  assign div_start = (state_q == S_LOAD) && (mode_q == MODE_AVG) && (seg[0].cnt != '0);
  assign load_last = ({1'b0, idx_q} + (IDX_W+1)'(1)) == (IDX_W+1)'(active);

  ssp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag),
    .divisor_i  (seg[0].cnt),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Saturate the quotient magnitude and restore its sign.
  always_comb begin
    if (neg_q) begin
      avg_res = (div_quot > ACC_W'(32768)) ? VAL_MIN : -$signed(div_quot[VAL_W-1:0]);
    end else begin
      avg_res = (div_quot > ACC_W'(32767)) ? VAL_MAX : $signed(div_quot[VAL_W-1:0]);
    end
  end

  // Emission sequencer with its registered outputs and the registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_ACCUM;
      mode_q      <= MODE_MAX;
      nseg_q      <= NSEG_W'(64);
      idx_q       <= '0;
      last_q      <= 1'b0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_wr) begin
        if (paddr[2] == REG_POOL_MODE) begin
          mode_q <= pwdata[0];
        end else begin
          nseg_q <= pwdata[NSEG_W-1:0];
        end
      end
      unique case (state_q)
        S_ACCUM: begin
          if (in_acc && in_req_i.end_of_channel) begin
            state_q <= S_LOAD;
            idx_q   <= '0;
          end
        end
        S_LOAD: begin
          last_q            <= load_last;
          neg_q             <= seg[0].acc[ACC_W-1];
          out_q.label_index <= IDX_OUT_W'(idx_q);
          out_q.last_result <= load_last;
          out_q.empty_segment <= (seg[0].cnt == '0);
          if (seg[0].cnt == '0) begin
            out_q.pooled_value <= (mode_q == MODE_MAX) ? VAL_MIN : '0;
            out_valid_q        <= 1'b1;
            state_q            <= S_OUT;
          end else if (mode_q == MODE_MAX) begin
            out_q.pooled_value <= seg[0].acc[VAL_W-1:0];
            out_valid_q        <= 1'b1;
            state_q            <= S_OUT;
          end else begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            out_q.pooled_value <= avg_res;
            out_valid_q        <= 1'b1;
            state_q            <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_acc) begin
            out_valid_q <= 1'b0;
            if (last_q) begin
              state_q <= S_ACCUM;
              idx_q   <= '0;
            end else begin
              state_q <= S_LOAD;
              idx_q   <= idx_q + 1'b1;
            end
          end
        end
        default: begin
          state_q <= S_ACCUM;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

// ===== rtl/ssp_cell.sv =====
// One segment cell: running max or saturating sum and count for one label.
// During emission the cell takes its neighbor's contents. Uses ssp_pkg.
module ssp_cell import ssp_pkg::*; #(
  parameter int unsigned CELL_ID = 0
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ssp_cell_ctl_t           ctl_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  logic [LBL_W-1:0]        label_i,
  input  ssp_seg_t                next_i,
  output ssp_seg_t                seg_o
);

  ssp_seg_t seg_q, seg_d;
  logic hit;
  logic signed [ACC_W:0] sum;
  logic signed [ACC_W-1:0] val_ext;

  assign hit     = ctl_i.upd && (label_i == LBL_W'(CELL_ID));
  assign val_ext = ACC_W'(value_i);
  assign sum     = {seg_q.acc[ACC_W-1], seg_q.acc} + (ACC_W+1)'(value_i);

  // Next contents: clear, shift from the neighbor, or absorb a pixel.
  always_comb begin
    seg_d = seg_q;
    if (ctl_i.clr) begin
      seg_d = '0;
    end else if (ctl_i.shift) begin
      seg_d = next_i;
    end else if (hit) begin
      if (ctl_i.avg) begin
        if (sum[ACC_W] != sum[ACC_W-1]) begin
          seg_d.acc = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
          seg_d.acc = sum[ACC_W-1:0];
        end
      end else if ((seg_q.cnt == '0) || (val_ext > seg_q.acc)) begin
        seg_d.acc = val_ext;
      end
      if (seg_q.cnt != '1) begin
        seg_d.cnt = seg_q.cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q <= '0;
    end else begin
      seg_q <= seg_d;
    end
  end

  assign seg_o = seg_q;

endmodule

// ===== rtl/ssp_div.sv =====
// Bit-serial restoring divider: unsigned sum magnitude over pixel count.
// One quotient bit per cycle. Uses ssp_pkg.
module ssp_div import ssp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [ACC_W-1:0] dividend_i,
  input  logic [CNT_W-1:0] divisor_i,
  output logic             done_o,
  output logic [ACC_W-1:0] quot_o
);

  localparam int unsigned STEP_W = $clog2(ACC_W + 1);

  logic [ACC_W-1:0]  quot_q, quot_d;
  logic [CNT_W:0]    rem_q, rem_d;
  logic [CNT_W-1:0]  dvs_q;
  logic [STEP_W-1:0] step_q, step_d;
  logic              done_q, done_d;
  logic [CNT_W:0]    rem_sh;

  assign rem_sh = {rem_q[CNT_W-1:0], quot_q[ACC_W-1]};

  // One restoring step per cycle while steps remain.
  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    step_d = step_q;
    done_d = 1'b0;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      step_d = STEP_W'(ACC_W);
    end else if (step_q != '0) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d  = rem_sh - {1'b0, dvs_q};
        quot_d = {quot_q[ACC_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        quot_d = {quot_q[ACC_W-2:0], 1'b0};
      end
      step_d = step_q - 1'b1;
      done_d = (step_q == STEP_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== rtl/ssp_checker.sv =====
// Port-level checks for the superpixel segment pooling block, bound to the
// top level. Uses ssp_pkg.
module ssp_checker import ssp_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input ssp_out_t out_res_o
);

  // A stalled result holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_res_o))
    else $error("stalled result changed");

  // No pixel request is taken while results are being emitted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("pixel taken during emission");

  // Once the final result is taken, emission is over.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_res_o.last_result |=> !out_valid_o && !in_stall_o)
    else $error("emission did not end after last result");

  // An empty segment reports the mode's empty value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.empty_segment |->
      (out_res_o.pooled_value == VAL_MIN) || (out_res_o.pooled_value == '0))
    else $error("bad value for empty segment");

endmodule

bind superpixel_segment_pooling ssp_checker u_ssp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_res_o   (out_res_o)
);
